>>> rtl/aosrs_pkg.sv
`default_nettype none

package aosrs_pkg;

	// request codes
	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_LOCATE = 3'd1;
	localparam logic [2:0] REQ_READ = 3'd2;
	localparam logic [2:0] REQ_ERASE = 3'd3;
	localparam logic [2:0] REQ_RAW = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_LEN = 2'd1;
	localparam logic [1:0] STAT_OPEN = 2'd2;
	localparam logic [1:0] STAT_NONE = 2'd3;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] TRAILER_VERSION = 8'h01;

	// trailer byte offsets past the payload (the CRC pair counts header reads instead)
	localparam logic [2:0] TRL_LAST = 3'd7;
	localparam logic [2:0] TRL_MAGIC_LAST = 3'd3;
	localparam logic [2:0] TRL_CRC_LO = 3'd4;
	localparam logic [2:0] TRL_CRC_HI = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_ERASE,
		ST_PROG_RD,
		ST_PROG_WR,
		ST_LOC_RD,
		ST_LOC_CHK,
		ST_CRC_RD,
		ST_CRC_CHK,
		ST_READ_RD,
		ST_READ_DONE,
		ST_RESP
	} state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	// trailer layout: magic, version (little endian), crc (low byte first)
	function automatic logic [7:0] trailer_byte(input logic [2:0] k, input logic [15:0] crc);
		logic [7:0] r;
		unique case (k)
			3'd0: r = 8'h42;
			3'd1: r = 8'h53;
			3'd2: r = 8'h50;
			3'd3: r = 8'h47;
			3'd4: r = TRAILER_VERSION;
			3'd5: r = 8'h00;
			3'd6: r = crc[7:0];
			default: r = crc[15:8];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/aosrs_flash.sv
`default_nettype none

module aosrs_flash #(
	parameter int DEPTH = 8192,
	parameter int AW = 13
) (
	input wire logic clk,
	input wire logic re,
	input wire logic we,
	input wire logic [AW-1:0] addr,
	input wire logic [7:0] wdata,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/append_only_slot_record_store.sv
// Append-only slot record store over a byte-wide flash image.
// Input channel (in_valid / in_stall) carries one request transaction:
// req_type, record, data_byte, address, last. Output channel (out_valid /
// out_stall) carries at most one result transaction per request: status,
// slot, rd_byte.
// One request is worked at a time; the whole flash image sits in a single
// port memory with a registered read, and every access below goes through
// that port. The steps of each request, from acceptance on:
//   write_byte   : per payload byte: accept, decode, read, AND-program; when a
//                  write opens, first a free-slot scan that reads and checks
//                  each trailer magic byte, and a sector erase when no slot is
//                  free; then the trailer, programmed byte by byte.
//   locate       : per slot scanned, the header reads (magic and CRC) and
//                  a CRC walk over the payload.
//   read_byte    : decode, read, result; erase: decode, sector erase, result;
//   raw_program  : decode, read, AND-program, result.
// After reset a clearing pass writes 0xFF into every image byte, one byte a
// cycle; in_stall stays high meanwhile.
// A finished result waits in the output register while out_stall is high; the
// next request is still accepted and runs until its own result is due.
`default_nettype none

module append_only_slot_record_store #(
	parameter int RECORDS = 4,
	parameter int SLOTS = 4,
	parameter int SLOT_BYTES = 512,
	parameter int PAYLOAD_BYTES = 480
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] req_type,
	input wire logic [1:0] record,
	input wire logic [7:0] data_byte,
	input wire logic [12:0] address,
	input wire logic last,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [1:0] slot,
	output logic [7:0] rd_byte
);

	localparam int SECTOR_BYTES = SLOTS * SLOT_BYTES;
	localparam int IMAGE_BYTES = RECORDS * SECTOR_BYTES;
	localparam int AW = $clog2(IMAGE_BYTES);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(PAYLOAD_BYTES + 1);

	function automatic logic [AW-1:0] slot_start(input logic [1:0] r, input logic [SW-1:0] s);
		return AW'(32'(r) * SECTOR_BYTES + 32'(s) * SLOT_BYTES);
	endfunction

	aosrs_pkg::state_t state_q, state_d;

	logic [2:0] rt_q;
	logic [1:0] rec_q;
	logic [7:0] db_q;
	logic [12:0] addr_q;
	logic last_q;

	logic wopen_q, wopen_d;
	logic [SW-1:0] wslot_q, wslot_d;
	logic [CW-1:0] wcount_q, wcount_d;
	logic [15:0] crc_q, crc_d;
	logic [AW-1:0] wbase_q, wbase_d;
	logic [SW-1:0] lslot_q, lslot_d;
	logic lvalid_q, lvalid_d;

	logic [SW-1:0] s_q, s_d;
	logic [2:0] k_q, k_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] end_q, end_d;
	logic [AW-1:0] base_q, base_d;
	logic [7:0] pbyte_q, pbyte_d;
	logic trl_q, trl_d;
	logic [15:0] stored_q, stored_d;
	logic [15:0] calc_q, calc_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [1:0] res_status_q, res_status_d;
	logic [1:0] res_slot_q, res_slot_d;
	logic [7:0] res_data_q, res_data_d;

	logic mem_re, mem_we;
	logic [7:0] mem_wdata, mem_rdata;
	logic [2:0] hdr_off;
	logic [15:0] crc_next;
	logic [CW-1:0] wcount_inc;
	logic accept, rec_ok, load_out;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != aosrs_pkg::ST_IDLE);
	assign rec_ok = (32'(rec_q) < RECORDS);
	assign load_out = (state_q == aosrs_pkg::ST_RESP) && (!out_valid || !out_stall);
	assign crc_next = aosrs_pkg::crc_byte(calc_q, mem_rdata);
	assign wcount_inc = wcount_q + CW'(1);
	// offset past the payload of the next header byte: magic, then skip the version
	assign hdr_off = (k_q < aosrs_pkg::TRL_MAGIC_LAST) ? k_q + 3'd1 : k_q + 3'd3;

	aosrs_flash #(
		.DEPTH(IMAGE_BYTES),
		.AW(AW)
	) u_flash (
		.clk(clk),
		.re(mem_re),
		.we(mem_we),
		.addr(ptr_q),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aosrs_pkg::ST_CLEAR;
			ptr_q <= '0;
			wopen_q <= 1'b0;
			wslot_q <= '0;
			wcount_q <= '0;
			crc_q <= '0;
			lslot_q <= '0;
			lvalid_q <= 1'b0;
			s_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			trl_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q <= ptr_d;
			wopen_q <= wopen_d;
			wslot_q <= wslot_d;
			wcount_q <= wcount_d;
			crc_q <= crc_d;
			lslot_q <= lslot_d;
			lvalid_q <= lvalid_d;
			s_q <= s_d;
			k_q <= k_d;
			cnt_q <= cnt_d;
			trl_q <= trl_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rt_q <= req_type;
			rec_q <= record;
			db_q <= data_byte;
			addr_q <= address;
			last_q <= last;
		end
		wbase_q <= wbase_d;
		end_q <= end_d;
		base_q <= base_d;
		pbyte_q <= pbyte_d;
		stored_q <= stored_d;
		calc_q <= calc_d;
		res_status_q <= res_status_d;
		res_slot_q <= res_slot_d;
		res_data_q <= res_data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status <= res_status_q;
			slot <= res_slot_q;
			rd_byte <= res_data_q;
		end
	end

	always_comb begin
		state_d = state_q;
		wopen_d = wopen_q;
		wslot_d = wslot_q;
		wcount_d = wcount_q;
		crc_d = crc_q;
		wbase_d = wbase_q;
		lslot_d = lslot_q;
		lvalid_d = lvalid_q;
		s_d = s_q;
		k_d = k_q;
		ptr_d = ptr_q;
		end_d = end_q;
		base_d = base_q;
		pbyte_d = pbyte_q;
		trl_d = trl_q;
		stored_d = stored_q;
		calc_d = calc_q;
		cnt_d = cnt_q;
		res_status_d = res_status_q;
		res_slot_d = res_slot_q;
		res_data_d = res_data_q;
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_wdata = aosrs_pkg::ERASED_BYTE;

		unique case (state_q)
			aosrs_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				ptr_d = ptr_q + AW'(1);
				if (ptr_q == AW'(IMAGE_BYTES - 1)) begin
					ptr_d = '0;
					state_d = aosrs_pkg::ST_IDLE;
				end
			end
			aosrs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = aosrs_pkg::ST_DECODE;
				end
			end
			aosrs_pkg::ST_DECODE: begin
				res_status_d = aosrs_pkg::STAT_OK;
				res_slot_d = 2'b00;
				res_data_d = 8'h00;
				if (rt_q > aosrs_pkg::REQ_RAW) begin
					// unknown request: no result
					state_d = aosrs_pkg::ST_IDLE;
				end else if (rt_q == aosrs_pkg::REQ_WRITE) begin
					trl_d = 1'b0;
					if (wopen_q) begin
						ptr_d = wbase_q + AW'(wcount_q);
						pbyte_d = db_q;
						state_d = aosrs_pkg::ST_PROG_RD;
					end else if (!rec_ok) begin
						state_d = aosrs_pkg::ST_IDLE;
					end else begin
						// find the first slot whose magic reads erased
						s_d = '0;
						k_d = '0;
						base_d = slot_start(rec_q, '0);
						ptr_d = slot_start(rec_q, '0) + AW'(PAYLOAD_BYTES);
						state_d = aosrs_pkg::ST_SCAN_RD;
					end
				end else if (wopen_q) begin
					res_status_d = aosrs_pkg::STAT_OPEN;
					state_d = aosrs_pkg::ST_RESP;
				end else begin
					unique case (rt_q)
						aosrs_pkg::REQ_LOCATE: begin
							lvalid_d = 1'b0;
							lslot_d = '0;
							if (!rec_ok) begin
								res_status_d = aosrs_pkg::STAT_NONE;
								res_data_d = aosrs_pkg::ERASED_BYTE;
								state_d = aosrs_pkg::ST_RESP;
							end else begin
								s_d = SW'(SLOTS - 1);
								k_d = '0;
								base_d = slot_start(rec_q, SW'(SLOTS - 1));
								ptr_d = slot_start(rec_q, SW'(SLOTS - 1)) + AW'(PAYLOAD_BYTES);
								state_d = aosrs_pkg::ST_LOC_RD;
							end
						end
						aosrs_pkg::REQ_READ: begin
							if (!lvalid_q || !rec_ok) begin
								res_status_d = aosrs_pkg::STAT_NONE;
								res_data_d = aosrs_pkg::ERASED_BYTE;
								state_d = aosrs_pkg::ST_RESP;
							end else if (32'(addr_q) >= PAYLOAD_BYTES) begin
								res_slot_d = 2'(lslot_q);
								res_data_d = aosrs_pkg::ERASED_BYTE;
								state_d = aosrs_pkg::ST_RESP;
							end else begin
								res_slot_d = 2'(lslot_q);
								ptr_d = slot_start(rec_q, lslot_q) + AW'(addr_q);
								state_d = aosrs_pkg::ST_READ_RD;
							end
						end
						aosrs_pkg::REQ_ERASE: begin
							if (rec_ok) begin
								lvalid_d = 1'b0;
								ptr_d = slot_start(rec_q, '0);
								end_d = slot_start(rec_q, '0) + AW'(SECTOR_BYTES - 1);
								state_d = aosrs_pkg::ST_ERASE;
							end else begin
								state_d = aosrs_pkg::ST_RESP;
							end
						end
						default: begin
							lvalid_d = 1'b0;
							if (32'(addr_q) < IMAGE_BYTES) begin
								ptr_d = AW'(addr_q);
								pbyte_d = db_q;
								trl_d = 1'b0;
								state_d = aosrs_pkg::ST_PROG_RD;
							end else begin
								state_d = aosrs_pkg::ST_RESP;
							end
						end
					endcase
				end
			end
			aosrs_pkg::ST_SCAN_RD: begin
				mem_re = 1'b1;
				state_d = aosrs_pkg::ST_SCAN_CHK;
			end
			aosrs_pkg::ST_SCAN_CHK: begin
				if (mem_rdata != aosrs_pkg::ERASED_BYTE) begin
					if (s_q == SW'(SLOTS - 1)) begin
						// sector full: erase it and take slot 0
						ptr_d = slot_start(rec_q, '0);
						end_d = slot_start(rec_q, '0) + AW'(SECTOR_BYTES - 1);
						state_d = aosrs_pkg::ST_ERASE;
					end else begin
						s_d = s_q + SW'(1);
						k_d = '0;
						base_d = base_q + AW'(SLOT_BYTES);
						ptr_d = base_q + AW'(SLOT_BYTES) + AW'(PAYLOAD_BYTES);
						state_d = aosrs_pkg::ST_SCAN_RD;
					end
				end else if (k_q == aosrs_pkg::TRL_MAGIC_LAST) begin
					wopen_d = 1'b1;
					wslot_d = s_q;
					wcount_d = '0;
					crc_d = '0;
					lvalid_d = 1'b0;
					wbase_d = base_q;
					ptr_d = base_q;
					pbyte_d = db_q;
					state_d = aosrs_pkg::ST_PROG_RD;
				end else begin
					k_d = k_q + 3'd1;
					ptr_d = ptr_q + AW'(1);
					state_d = aosrs_pkg::ST_SCAN_RD;
				end
			end
			aosrs_pkg::ST_ERASE: begin
				mem_we = 1'b1;
				ptr_d = ptr_q + AW'(1);
				if (ptr_q == end_q) begin
					if (rt_q == aosrs_pkg::REQ_WRITE) begin
						wopen_d = 1'b1;
						wslot_d = '0;
						wcount_d = '0;
						crc_d = '0;
						lvalid_d = 1'b0;
						wbase_d = slot_start(rec_q, '0);
						ptr_d = slot_start(rec_q, '0);
						pbyte_d = db_q;
						state_d = aosrs_pkg::ST_PROG_RD;
					end else begin
						state_d = aosrs_pkg::ST_RESP;
					end
				end
			end
			aosrs_pkg::ST_PROG_RD: begin
				mem_re = 1'b1;
				state_d = aosrs_pkg::ST_PROG_WR;
			end
			aosrs_pkg::ST_PROG_WR: begin
				// flash programming only clears bits
				mem_we = 1'b1;
				mem_wdata = mem_rdata & pbyte_q;
				if (rt_q == aosrs_pkg::REQ_RAW) begin
					state_d = aosrs_pkg::ST_RESP;
				end else if (!trl_q) begin
					crc_d = aosrs_pkg::crc_byte(crc_q, db_q);
					wcount_d = wcount_inc;
					if (!last_q && (32'(wcount_inc) < PAYLOAD_BYTES)) begin
						state_d = aosrs_pkg::ST_IDLE;
					end else begin
						wopen_d = 1'b0;
						res_slot_d = 2'(wslot_q);
						if (!(last_q && (32'(wcount_inc) == PAYLOAD_BYTES))) begin
							res_status_d = aosrs_pkg::STAT_LEN;
							state_d = aosrs_pkg::ST_RESP;
						end else begin
							trl_d = 1'b1;
							k_d = '0;
							ptr_d = wbase_q + AW'(PAYLOAD_BYTES);
							pbyte_d = aosrs_pkg::trailer_byte('0, aosrs_pkg::crc_byte(crc_q, db_q));
							state_d = aosrs_pkg::ST_PROG_RD;
						end
					end
				end else if (k_q == aosrs_pkg::TRL_LAST) begin
					state_d = aosrs_pkg::ST_RESP;
				end else begin
					k_d = k_q + 3'd1;
					ptr_d = ptr_q + AW'(1);
					pbyte_d = aosrs_pkg::trailer_byte(k_q + 3'd1, crc_q);
					state_d = aosrs_pkg::ST_PROG_RD;
				end
			end
			aosrs_pkg::ST_LOC_RD: begin
				mem_re = 1'b1;
				state_d = aosrs_pkg::ST_LOC_CHK;
			end
			aosrs_pkg::ST_LOC_CHK: begin
				k_d = k_q + 3'd1;
				ptr_d = base_q + AW'(PAYLOAD_BYTES) + AW'(hdr_off);
				state_d = aosrs_pkg::ST_LOC_RD;
				if (k_q == aosrs_pkg::TRL_CRC_LO) begin
					stored_d[7:0] = mem_rdata;
				end else if (k_q == aosrs_pkg::TRL_CRC_HI) begin
					stored_d[15:8] = mem_rdata;
					cnt_d = '0;
					calc_d = '0;
					ptr_d = base_q;
					state_d = aosrs_pkg::ST_CRC_RD;
				end else if (mem_rdata != aosrs_pkg::trailer_byte(k_q, crc_q)) begin
					// magic mismatch: drop this slot
					if (s_q == '0) begin
						res_status_d = aosrs_pkg::STAT_NONE;
						res_data_d = aosrs_pkg::ERASED_BYTE;
						state_d = aosrs_pkg::ST_RESP;
					end else begin
						s_d = s_q - SW'(1);
						k_d = '0;
						base_d = base_q - AW'(SLOT_BYTES);
						ptr_d = base_q - AW'(SLOT_BYTES) + AW'(PAYLOAD_BYTES);
					end
				end
			end
			aosrs_pkg::ST_CRC_RD: begin
				mem_re = 1'b1;
				state_d = aosrs_pkg::ST_CRC_CHK;
			end
			aosrs_pkg::ST_CRC_CHK: begin
				calc_d = crc_next;
				cnt_d = cnt_q + CW'(1);
				ptr_d = ptr_q + AW'(1);
				state_d = aosrs_pkg::ST_CRC_RD;
				if (cnt_q == CW'(PAYLOAD_BYTES - 1)) begin
					if (crc_next == stored_q) begin
						lslot_d = s_q;
						lvalid_d = 1'b1;
						res_slot_d = 2'(s_q);
						state_d = aosrs_pkg::ST_RESP;
					end else if (s_q == '0) begin
						res_status_d = aosrs_pkg::STAT_NONE;
						res_data_d = aosrs_pkg::ERASED_BYTE;
						state_d = aosrs_pkg::ST_RESP;
					end else begin
						s_d = s_q - SW'(1);
						k_d = '0;
						base_d = base_q - AW'(SLOT_BYTES);
						ptr_d = base_q - AW'(SLOT_BYTES) + AW'(PAYLOAD_BYTES);
						state_d = aosrs_pkg::ST_LOC_RD;
					end
				end
			end
			aosrs_pkg::ST_READ_RD: begin
				mem_re = 1'b1;
				state_d = aosrs_pkg::ST_READ_DONE;
			end
			aosrs_pkg::ST_READ_DONE: begin
				res_data_d = mem_rdata;
				state_d = aosrs_pkg::ST_RESP;
			end
			aosrs_pkg::ST_RESP: begin
				// hold until the output register is free
				if (load_out) begin
					state_d = aosrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aosrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
